@@ src/prc_pkg.sv @@
`timescale 1ns / 1ps

package prc_pkg;

    // coordinate format, two's complement
    localparam int COORD_W = 32;
    // one extra bit for differences and magnitudes
    localparam int WIDE_W  = COORD_W + 1;
    // step counter of the serial multiply-divide unit
    localparam int CNT_W   = $clog2(2 * WIDE_W);
    localparam int CFG_IDX_W = 3;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [WIDE_W-1:0]  t_wide;

    typedef struct packed {
        t_coord vertex_x;
        t_coord vertex_y;
        logic   first_vertex;
        logic   final_vertex;
    } t_vertex;

    typedef struct packed {
        t_coord point_x;
        t_coord point_y;
        logic   piece_end;
        logic   last_of_item;
    } t_point;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT,
        CFG_TOP,
        CFG_RIGHT,
        CFG_BOTTOM,
        CFG_DOTS
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_CR_H,
        ST_CR_HW,
        ST_CR_V,
        ST_CR_VW,
        ST_POST,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_ENTRY,
        PH_EXIT,
        PH_BOTH1,
        PH_BOTH2
    } t_phase;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV,
        MD_FIN
    } t_md_state;

    // request to the multiply-divide unit: base + trunc(p * m / d), saturated
    typedef struct packed {
        logic   start;
        t_coord base;
        t_wide  p;
        t_wide  m;
        t_wide  d;
    } t_md_req;

    typedef struct packed {
        logic   done;
        t_coord result;
    } t_md_resp;

endpackage

@@ src/prc_muldiv.sv @@
`timescale 1ns / 1ps

module prc_muldiv (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  prc_pkg::t_md_req   i_req,
    output prc_pkg::t_md_resp  o_resp
);

    localparam int W  = prc_pkg::WIDE_W;
    localparam int CW = prc_pkg::COORD_W;
    localparam int SW = W + 2;

    function automatic logic [W-1:0] f_mag(input prc_pkg::t_wide v);
        logic [W-1:0] u;
        u = v;
        f_mag = v[W-1] ? (~u + W'(1)) : u;
    endfunction

    prc_pkg::t_md_state           r_st, n_st;
    logic [prc_pkg::CNT_W-1:0]    r_cnt;
    logic [W-1:0]                 r_mc, r_hi, r_lo, r_dv, r_rem, r_q;
    logic                         r_ovf, r_neg;
    prc_pkg::t_coord              r_base;

    logic [W:0]                   c_sum;
    logic [W:0]                   c_t;
    logic                         c_ge;
    logic [W:0]                   c_tdiff;
    logic [SW-1:0]                c_qext, c_sq, c_res;
    logic signed [SW-1:0]         c_ress;

    // multiply step: add multiplicand when low bit set, then shift right
    assign c_sum   = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mc} : {(W+1){1'b0}});
    // divide step: bring in next dividend bit, compare and subtract
    assign c_t     = {r_rem, r_hi[W-1]};
    assign c_ge    = c_t >= {1'b0, r_dv};
    assign c_tdiff = c_t - {1'b0, r_dv};

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            prc_pkg::MD_IDLE: if (i_req.start) n_st = prc_pkg::MD_MUL;
            prc_pkg::MD_MUL: if (r_cnt == prc_pkg::CNT_W'(W - 1)) n_st = prc_pkg::MD_DIV;
            prc_pkg::MD_DIV: if (r_cnt == prc_pkg::CNT_W'(2 * W - 1)) n_st = prc_pkg::MD_FIN;
            prc_pkg::MD_FIN: n_st = prc_pkg::MD_IDLE;
            default: n_st = prc_pkg::MD_IDLE;
        endcase
    end

    // result: signed quotient added to base, clamped to coordinate range
    always_comb begin
        c_qext = r_ovf ? {2'b00, {W{1'b1}}} : {2'b00, r_q};
        c_sq   = r_neg ? (~c_qext + SW'(1)) : c_qext;
        c_res  = {{(SW-CW){r_base[CW-1]}}, r_base} + c_sq;
        c_ress = c_res;
        o_resp.done = (r_st == prc_pkg::MD_FIN);
        if (c_ress > $signed({{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}})) begin
            o_resp.result = {1'b0, {(CW-1){1'b1}}};
        end else if (c_ress < $signed({{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}})) begin
            o_resp.result = {1'b1, {(CW-1){1'b0}}};
        end else begin
            o_resp.result = c_res[CW-1:0];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= prc_pkg::MD_IDLE;
            r_cnt <= '0;
        end else begin
            r_st <= n_st;
            if (r_st != n_st) r_cnt <= '0;
            else r_cnt <= r_cnt + prc_pkg::CNT_W'(1);
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_st)
            prc_pkg::MD_IDLE: begin
                if (i_req.start) begin
                    r_mc   <= f_mag(i_req.m);
                    r_lo   <= f_mag(i_req.p);
                    r_dv   <= f_mag(i_req.d);
                    r_hi   <= '0;
                    r_neg  <= i_req.p[W-1] ^ i_req.m[W-1] ^ i_req.d[W-1];
                    r_base <= i_req.base;
                    r_rem  <= '0;
                    r_q    <= '0;
                    r_ovf  <= 1'b0;
                end
            end
            prc_pkg::MD_MUL: begin
                r_hi <= c_sum[W:1];
                r_lo <= {c_sum[0], r_lo[W-1:1]};
            end
            prc_pkg::MD_DIV: begin
                r_rem <= c_ge ? c_tdiff[W-1:0] : c_t[W-1:0];
                r_hi  <= {r_hi[W-2:0], r_lo[W-1]};
                r_lo  <= {r_lo[W-2:0], 1'b0};
                r_ovf <= r_ovf | r_q[W-1];
                r_q   <= {r_q[W-2:0], c_ge};
            end
            default: ;
        endcase
    end

endmodule

@@ src/polyline_rect_clipper_top.sv @@
`timescale 1ns / 1ps

// Clips a stream of polyline vertices (signed fixed point, y down) to the rectangle
// set through the write port and sends out the visible points, up to two per vertex.
// Each crossing of a sloped segment is worked out in one shared bit-serial
// multiply-divide unit: a multiply of COORD_W+1 steps and a restoring divide of
// 2*COORD_W+2 steps; a crossing may need one or two such passes and a segment
// with both ends outside up to four. Results wait in a two-entry output queue,
// so the next vertex is taken while earlier results are still held by the
// consumer.
module polyline_rect_clipper_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  prc_pkg::t_vertex                  i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output prc_pkg::t_point                   o_out_data,
    input  logic                              i_cfg_we,
    input  logic [prc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [prc_pkg::COORD_W-1:0]       i_cfg_wdata
);

    function automatic prc_pkg::t_wide f_diff(input prc_pkg::t_coord a,
                                              input prc_pkg::t_coord b);
        f_diff = {a[prc_pkg::COORD_W-1], a} - {b[prc_pkg::COORD_W-1], b};
    endfunction

    function automatic logic f_rng(input prc_pkg::t_coord v, input prc_pkg::t_coord lo,
                                   input prc_pkg::t_coord hi);
        f_rng = (v >= lo) && (v <= hi);
    endfunction

    function automatic prc_pkg::t_coord f_clamp(input prc_pkg::t_coord v,
                                                input prc_pkg::t_coord lo,
                                                input prc_pkg::t_coord hi);
        f_clamp = (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // configuration and polyline state
    prc_pkg::t_coord   r_left, r_top, r_right, r_bottom;
    logic              r_dots;
    prc_pkg::t_coord   r_ax, r_ay;
    logic              r_pin;

    // current vertex and work registers
    prc_pkg::t_state   r_state, n_state;
    prc_pkg::t_phase   r_phase;
    prc_pkg::t_coord   r_bx, r_by, r_cx, r_cy;
    logic              r_first, r_fin, r_cin, r_oisb, r_cok;
    prc_pkg::t_point   r_res0, r_res1;
    logic [1:0]        r_nres, r_oidx;

    // output queue
    prc_pkg::t_point   r_fq [2];
    logic              r_fwr, r_frd;
    logic [1:0]        r_fcnt;

    prc_pkg::t_md_req  c_req;
    prc_pkg::t_md_resp c_resp;

    logic              c_in_acc, c_pop, c_push, c_cin, c_zero;
    logic              c_htop, c_hact, c_hflat, c_vflat, c_both_ok;
    prc_pkg::t_coord   c_ox, c_oy, c_yl, c_hvx, c_xe, c_vy, c_px, c_py;
    prc_pkg::t_point   c_pt;

    prc_muldiv u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (c_req),
        .o_resp  (c_resp)
    );

    // edge selection from the outside end of the segment
    always_comb begin
        c_ox    = r_oisb ? r_bx : r_ax;
        c_oy    = r_oisb ? r_by : r_ay;
        c_htop  = c_oy <= r_top;
        c_hact  = c_htop || (c_oy >= r_bottom);
        c_yl    = c_htop ? r_top : r_bottom;
        c_hflat = (r_ay == r_by);
        c_hvx   = (c_ox < r_left) ? r_left : r_right;
        c_xe    = (c_ox >= r_right) ? r_right : r_left;
        c_vflat = (r_ax == r_bx);
        c_vy    = (c_oy <= r_top) ? r_top : r_bottom;
        c_cin   = f_rng(r_bx, r_left, r_right) && f_rng(r_by, r_top, r_bottom);
        c_zero  = (r_left == '0) && (r_top == '0) && (r_right == '0) && (r_bottom == '0);
        c_px    = r_cok ? r_cx : f_clamp(r_oisb ? r_bx : r_ax, r_left, r_right);
        c_py    = r_cok ? r_cy : f_clamp(r_oisb ? r_by : r_ay, r_top, r_bottom);
        c_both_ok = r_cok
                 && f_rng(r_res0.point_x, r_left, r_right)
                 && f_rng(r_res0.point_y, r_top, r_bottom)
                 && f_rng(r_cx, r_left, r_right) && f_rng(r_cy, r_top, r_bottom)
                 && ((r_res0.point_x != r_cx) || (r_res0.point_y != r_cy));
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            prc_pkg::ST_IDLE: if (c_in_acc) n_state = prc_pkg::ST_EVAL;
            prc_pkg::ST_EVAL: begin
                if (r_dots || c_zero || r_first || (c_cin && r_pin))
                    n_state = prc_pkg::ST_OUT;
                else
                    n_state = prc_pkg::ST_CR_H;
            end
            prc_pkg::ST_CR_H: begin
                if (!c_hact) n_state = prc_pkg::ST_CR_V;
                else if (!c_hflat) n_state = prc_pkg::ST_CR_HW;
                else if ((r_ay == c_yl) && f_rng(c_hvx, r_left, r_right))
                    n_state = prc_pkg::ST_POST;
                else n_state = prc_pkg::ST_CR_V;
            end
            prc_pkg::ST_CR_HW: begin
                if (c_resp.done) begin
                    if (f_rng(c_resp.result, r_left, r_right)) n_state = prc_pkg::ST_POST;
                    else n_state = prc_pkg::ST_CR_V;
                end
            end
            prc_pkg::ST_CR_V: n_state = c_vflat ? prc_pkg::ST_POST : prc_pkg::ST_CR_VW;
            prc_pkg::ST_CR_VW: if (c_resp.done) n_state = prc_pkg::ST_POST;
            prc_pkg::ST_POST: begin
                if ((r_phase == prc_pkg::PH_BOTH1) && r_cok) n_state = prc_pkg::ST_CR_H;
                else n_state = prc_pkg::ST_OUT;
            end
            prc_pkg::ST_OUT: if (r_oidx == r_nres) n_state = prc_pkg::ST_IDLE;
            default: n_state = prc_pkg::ST_IDLE;
        endcase
    end

    // outputs and unit requests
    always_comb begin
        o_in_stall  = (r_state != prc_pkg::ST_IDLE);
        c_in_acc    = i_in_valid && !o_in_stall;
        o_out_valid = (r_fcnt != 2'd0);
        o_out_data  = r_fq[r_frd];
        c_pop       = o_out_valid && !i_out_stall;
        c_push      = (r_state == prc_pkg::ST_OUT) && (r_oidx != r_nres) && (r_fcnt != 2'd2);
        c_pt        = (r_oidx == 2'd0) ? r_res0 : r_res1;
        c_pt.last_of_item = ((r_oidx + 2'd1) == r_nres);
        c_req.start = ((r_state == prc_pkg::ST_CR_H) && c_hact && !c_hflat)
                   || ((r_state == prc_pkg::ST_CR_V) && !c_vflat);
        if (r_state == prc_pkg::ST_CR_V) begin
            c_req.p    = f_diff(c_xe, r_ax);
            c_req.m    = f_diff(r_by, r_ay);
            c_req.d    = f_diff(r_bx, r_ax);
            c_req.base = r_ay;
        end else begin
            c_req.p    = f_diff(c_yl, r_ay);
            c_req.m    = f_diff(r_bx, r_ax);
            c_req.d    = f_diff(r_by, r_ay);
            c_req.base = r_ax;
        end
    end

    // control, configuration and polyline state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= prc_pkg::ST_IDLE;
            r_left   <= '0;
            r_top    <= '0;
            r_right  <= '0;
            r_bottom <= '0;
            r_dots   <= 1'b0;
            r_ax     <= '0;
            r_ay     <= '0;
            r_pin    <= 1'b0;
            r_fwr    <= 1'b0;
            r_frd    <= 1'b0;
            r_fcnt   <= '0;
            r_oidx   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    prc_pkg::CFG_LEFT:   r_left   <= i_cfg_wdata;
                    prc_pkg::CFG_TOP:    r_top    <= i_cfg_wdata;
                    prc_pkg::CFG_RIGHT:  r_right  <= i_cfg_wdata;
                    prc_pkg::CFG_BOTTOM: r_bottom <= i_cfg_wdata;
                    prc_pkg::CFG_DOTS:   r_dots   <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (r_state == prc_pkg::ST_EVAL) r_oidx <= '0;
            if (c_push) r_oidx <= r_oidx + 2'd1;
            if ((r_state == prc_pkg::ST_OUT) && (r_oidx == r_nres)) begin
                r_ax  <= r_bx;
                r_ay  <= r_by;
                r_pin <= r_cin;
            end
            if (c_push) r_fwr <= ~r_fwr;
            if (c_pop) r_frd <= ~r_frd;
            r_fcnt <= r_fcnt + {1'b0, c_push} - {1'b0, c_pop};
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (c_push) r_fq[r_fwr] <= c_pt;
        case (r_state)
            prc_pkg::ST_IDLE: begin
                if (c_in_acc) begin
                    r_bx    <= i_in_data.vertex_x;
                    r_by    <= i_in_data.vertex_y;
                    r_first <= i_in_data.first_vertex;
                    r_fin   <= i_in_data.final_vertex;
                end
            end
            prc_pkg::ST_EVAL: begin
                r_cin  <= c_cin;
                // dots always end a piece; pass-through and inside vertices follow the mark
                r_res0 <= '{point_x: r_bx, point_y: r_by, piece_end: r_dots | r_fin,
                            last_of_item: 1'b0};
                // direct results; crossing paths fill the count later
                r_nres <= (!r_dots && c_zero) ? 2'd1
                        : ((c_cin && (r_dots || r_first || r_pin)) ? 2'd1 : 2'd0);
                // crossing kind, used only when a crossing follows
                r_oisb  <= !c_cin && r_pin;
                r_phase <= c_cin ? prc_pkg::PH_ENTRY
                         : (r_pin ? prc_pkg::PH_EXIT : prc_pkg::PH_BOTH1);
            end
            prc_pkg::ST_CR_H: begin
                r_cx  <= c_hvx;
                r_cy  <= c_yl;
                r_cok <= 1'b1;
            end
            prc_pkg::ST_CR_HW: begin
                r_cx  <= c_resp.result;
                r_cy  <= c_yl;
                r_cok <= 1'b1;
            end
            prc_pkg::ST_CR_V: begin
                r_cx  <= c_xe;
                r_cy  <= c_vy;
                r_cok <= (r_ax == c_xe);
            end
            prc_pkg::ST_CR_VW: begin
                r_cx  <= c_xe;
                r_cy  <= c_resp.result;
                r_cok <= 1'b1;
            end
            prc_pkg::ST_POST: begin
                case (r_phase)
                    prc_pkg::PH_ENTRY: begin
                        r_res0 <= '{point_x: c_px, point_y: c_py, piece_end: 1'b0,
                                    last_of_item: 1'b0};
                        r_res1 <= '{point_x: r_bx, point_y: r_by, piece_end: r_fin,
                                    last_of_item: 1'b0};
                        r_nres <= 2'd2;
                    end
                    prc_pkg::PH_EXIT: begin
                        r_res0 <= '{point_x: c_px, point_y: c_py, piece_end: 1'b1,
                                    last_of_item: 1'b0};
                        r_nres <= 2'd1;
                    end
                    prc_pkg::PH_BOTH1: begin
                        r_res0 <= '{point_x: r_cx, point_y: r_cy, piece_end: 1'b0,
                                    last_of_item: 1'b0};
                        r_nres <= 2'd0;
                        r_oisb <= 1'b1;
                        r_phase <= prc_pkg::PH_BOTH2;
                    end
                    prc_pkg::PH_BOTH2: begin
                        r_res1 <= '{point_x: r_cx, point_y: r_cy, piece_end: 1'b1,
                                    last_of_item: 1'b0};
                        r_nres <= c_both_ok ? 2'd2 : 2'd0;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    // queue never holds more than its two entries
    a_fcnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt != 2'd3)
        else $error("output queue overflow");

    // divider completes only while a crossing waits for it
    a_md_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_resp.done |-> (r_state == prc_pkg::ST_CR_HW || r_state == prc_pkg::ST_CR_VW))
        else $error("divider result with no crossing pending");

    // an accepted transaction is evaluated next
    a_acc_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_in_acc |=> (r_state == prc_pkg::ST_EVAL))
        else $error("accepted vertex not evaluated");
`endif

endmodule
